// ----- rtl/gsc_pkg.sv -----
// Package: sizes, beat structures and helpers shared by the sink component finder.
package gsc_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 8192;
    localparam int VW  = $clog2(MAX_VERTICES + 1);
    localparam int VA  = $clog2(MAX_VERTICES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam int EA  = $clog2(MAX_EDGES);
    localparam int WORDS = (MAX_VERTICES + 63) / 64;
    localparam int KW  = $clog2(WORDS + 1);
    localparam int IW  = VA + 1;

    typedef struct packed {
        logic [VW-1:0] edge_source;
        logic [VW-1:0] edge_target;
        logic          edge_valid;
        logic          last_edge;
    } edge_item_t;

    typedef struct packed {
        logic [63:0] sink_mask;
        logic [5:0]  word_index;
        logic        last_word;
        logic        edge_overflow;
    } sink_word_t;

    function automatic logic [VA-1:0] vix(input logic [VW-1:0] v);
        logic [VW-1:0] d;
        d = v - 1'b1;
        return d[VA-1:0];
    endfunction

    function automatic logic [EA-1:0] eix(input logic [EW-1:0] e);
        logic [EW-1:0] d;
        d = e - 1'b1;
        return d[EA-1:0];
    endfunction

endpackage

// ----- rtl/gsc_ram.sv -----
// Generic single-write, single-read memory with registered read data.
module gsc_ram #(
    parameter int DW = 8,
    parameter int AW = 4
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/gsc_engine.sv -----
// Sequencer: edge list build, iterative Tarjan pass, exit marking and word output.
module gsc_engine
    import gsc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [VW-1:0] n,
    input  logic          in_valid,
    output logic          in_ready,
    input  edge_item_t    in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output sink_word_t    out_word
);
    localparam logic [4:0] S_CLRH = 5'd0,  S_IDLE = 5'd1,  S_EDGE = 5'd2,  S_CLR = 5'd3,
                           S_ROOT = 5'd4,  S_ROOTW = 5'd5, S_ENT = 5'd6,   S_ENT2 = 5'd7,
                           S_TOP = 5'd8,   S_TOPW = 5'd9,  S_EW = 5'd10,   S_EW2 = 5'd11,
                           S_FIN = 5'd12,  S_POP = 5'd13,  S_POPW = 5'd14, S_RET = 5'd15,
                           S_RETW = 5'd16, S_RETW2 = 5'd17, S_MK = 5'd18,  S_MKW = 5'd19,
                           S_MKL = 5'd20,  S_MKE = 5'd21,  S_MKC = 5'd22,  S_OB = 5'd23,
                           S_OBW = 5'd24,  S_OBX = 5'd25,  S_WAIT = 5'd26;

    logic [4:0]    state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [VW-1:0] r_reg, r_next, seq_reg, seq_next, sp0_reg, sp0_next, sp1_reg, sp1_next;
    logic [VW-1:0] comps_reg, comps_next, x_reg, x_next, v_reg, v_next, u_reg, u_next;
    logic [VW-1:0] lowv_reg, lowv_next, cv_reg, cv_next;
    logic [EW-1:0] e_reg, e_next, nxt_reg, nxt_next, total_reg, total_next;
    logic          ovf_reg, ovf_next, cz_reg, cz_next;
    logic [KW-1:0] k_reg, k_next;
    logic [63:0]   mask_reg, mask_next;
    edge_item_t    item_reg, item_next;
    logic          ov_reg, ov_next;
    sink_word_t    ow_reg, ow_next;

    logic          hd_we, ds_we, lw_we, cp_we, ex_we, sc_we, cv_we, ce_we, tg_we, nx_we;
    logic [VA-1:0] hd_wa, ds_wa, lw_wa, cp_wa, ex_wa, sc_wa, cv_wa, ce_wa;
    logic [VA-1:0] hd_ra, ds_ra, lw_ra, cp_ra, ex_ra, sc_ra, cv_ra, ce_ra;
    logic [EA-1:0] tg_wa, nx_wa, tg_ra, nx_ra;
    logic [EW-1:0] hd_wd, hd_rd, ce_wd, ce_rd, nx_wd, nx_rd;
    logic [VW-1:0] ds_wd, ds_rd, lw_wd, lw_rd, cp_wd, cp_rd, sc_wd, sc_rd, cv_wd, cv_rd;
    logic [VW-1:0] tg_wd, tg_rd;
    logic          ex_wd, ex_rd;

    logic [KW-1:0] words;
    logic [11:0]   wsum;
    logic          bit_last;

    gsc_ram #(.DW(EW), .AW(VA)) u_head (aclk, hd_we, hd_wa, hd_wd, hd_ra, hd_rd);
    gsc_ram #(.DW(VW), .AW(VA)) u_disc (aclk, ds_we, ds_wa, ds_wd, ds_ra, ds_rd);
    gsc_ram #(.DW(VW), .AW(VA)) u_low  (aclk, lw_we, lw_wa, lw_wd, lw_ra, lw_rd);
    gsc_ram #(.DW(VW), .AW(VA)) u_comp (aclk, cp_we, cp_wa, cp_wd, cp_ra, cp_rd);
    gsc_ram #(.DW(1),  .AW(VA)) u_exit (aclk, ex_we, ex_wa, ex_wd, ex_ra, ex_rd);
    gsc_ram #(.DW(VW), .AW(VA)) u_scc  (aclk, sc_we, sc_wa, sc_wd, sc_ra, sc_rd);
    gsc_ram #(.DW(VW), .AW(VA)) u_csv  (aclk, cv_we, cv_wa, cv_wd, cv_ra, cv_rd);
    gsc_ram #(.DW(EW), .AW(VA)) u_cse  (aclk, ce_we, ce_wa, ce_wd, ce_ra, ce_rd);
    gsc_ram #(.DW(VW), .AW(EA)) u_tgt  (aclk, tg_we, tg_wa, tg_wd, tg_ra, tg_rd);
    gsc_ram #(.DW(EW), .AW(EA)) u_nxt  (aclk, nx_we, nx_wa, nx_wd, nx_ra, nx_rd);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;
    assign wsum      = {1'b0, n} + 12'd63;
    assign words     = (wsum[11:6] == 6'd0) ? KW'(1) : KW'(wsum[11:6]);
    assign bit_last  = (i_reg[5:0] == 6'h3f);

    always_comb begin
        logic in_rng;
        logic [VW-1:0] w;
        state_next = state_reg; i_next = i_reg; r_next = r_reg; seq_next = seq_reg;
        sp0_next = sp0_reg; sp1_next = sp1_reg; comps_next = comps_reg; x_next = x_reg;
        v_next = v_reg; u_next = u_reg; lowv_next = lowv_reg; cv_next = cv_reg;
        e_next = e_reg; nxt_next = nxt_reg; total_next = total_reg; ovf_next = ovf_reg;
        cz_next = cz_reg; k_next = k_reg; mask_next = mask_reg; item_next = item_reg;
        ov_next = ov_reg; ow_next = ow_reg;
        hd_we = 1'b0; ds_we = 1'b0; lw_we = 1'b0; cp_we = 1'b0; ex_we = 1'b0;
        sc_we = 1'b0; cv_we = 1'b0; ce_we = 1'b0; tg_we = 1'b0; nx_we = 1'b0;
        hd_wa = i_reg[VA-1:0]; ds_wa = i_reg[VA-1:0]; lw_wa = vix(v_reg);
        cp_wa = i_reg[VA-1:0]; ex_wa = i_reg[VA-1:0]; sc_wa = sp0_reg[VA-1:0];
        cv_wa = sp1_reg[VA-1:0]; ce_wa = sp1_reg[VA-1:0];
        tg_wa = total_reg[EA-1:0]; nx_wa = total_reg[EA-1:0];
        hd_wd = '0; ds_wd = '0; lw_wd = '0; cp_wd = '0; ex_wd = 1'b0; sc_wd = x_reg;
        cv_wd = x_reg; ce_wd = hd_rd; tg_wd = item_reg.edge_target; nx_wd = hd_rd;
        hd_ra = vix(x_reg); ds_ra = vix(r_reg); lw_ra = vix(v_reg); cp_ra = vix(r_reg);
        ex_ra = '0; sc_ra = '0; cv_ra = '0; ce_ra = '0; tg_ra = eix(e_reg); nx_ra = eix(e_reg);
        w = tg_rd;
        in_rng = (in_item.edge_source != '0) && (in_item.edge_source <= n) &&
                 (in_item.edge_target != '0) && (in_item.edge_target <= n);
        unique case (state_reg)
            S_CLRH: begin
                hd_we = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg[VA-1:0] == VA'(MAX_VERTICES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    item_next = in_item;
                    i_next = '0;
                    hd_ra = vix(in_item.edge_source);
                    if (in_item.edge_valid && in_rng && total_reg < EW'(MAX_EDGES)) begin
                        state_next = S_EDGE;
                    end else begin
                        if (in_item.edge_valid && in_rng) begin
                            ovf_next = 1'b1;
                        end
                        if (in_item.last_edge) begin
                            state_next = S_CLR;
                        end
                    end
                end
            end
            S_EDGE: begin
                tg_we = 1'b1; nx_we = 1'b1; hd_we = 1'b1;
                hd_wa = vix(item_reg.edge_source);
                hd_wd = total_reg + 1'b1;
                total_next = total_reg + 1'b1;
                state_next = item_reg.last_edge ? S_CLR : S_IDLE;
            end
            S_CLR: begin
                ds_we = 1'b1; cp_we = 1'b1; ex_we = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg[VA-1:0] == VA'(MAX_VERTICES - 1)) begin
                    r_next = VW'(1); seq_next = '0; sp0_next = '0; sp1_next = '0;
                    comps_next = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_reg > n) begin
                    r_next = VW'(1);
                    state_next = S_MK;
                end else begin
                    state_next = S_ROOTW;
                end
            end
            S_ROOTW: begin
                if (ds_rd != '0) begin
                    r_next = r_reg + 1'b1;
                    state_next = S_ROOT;
                end else begin
                    x_next = r_reg;
                    state_next = S_ENT;
                end
            end
            S_ENT: begin
                ds_we = 1'b1; ds_wa = vix(x_reg); ds_wd = seq_reg + 1'b1;
                lw_we = 1'b1; lw_wa = vix(x_reg); lw_wd = seq_reg + 1'b1;
                sc_we = 1'b1;
                seq_next = seq_reg + 1'b1;
                sp0_next = sp0_reg + 1'b1;
                state_next = S_ENT2;
            end
            S_ENT2: begin
                cv_we = 1'b1; ce_we = 1'b1;
                sp1_next = sp1_reg + 1'b1;
                state_next = S_TOP;
            end
            S_TOP: begin
                cv_ra = vix(sp1_reg); ce_ra = vix(sp1_reg);
                if (sp1_reg == '0) begin
                    r_next = r_reg + 1'b1;
                    state_next = S_ROOT;
                end else begin
                    state_next = S_TOPW;
                end
            end
            S_TOPW: begin
                v_next = cv_rd; e_next = ce_rd;
                tg_ra = eix(ce_rd); nx_ra = eix(ce_rd);
                lw_ra = vix(cv_rd); ds_ra = vix(cv_rd);
                state_next = (ce_rd != '0) ? S_EW : S_FIN;
            end
            S_EW: begin
                ce_we = 1'b1; ce_wa = vix(sp1_reg); ce_wd = nx_rd;
                ds_ra = vix(w); cp_ra = vix(w); lw_ra = vix(v_reg);
                state_next = (w != '0 && w <= n) ? S_EW2 : S_TOP;
            end
            S_EW2: begin
                x_next = tg_rd;
                if (ds_rd == '0) begin
                    state_next = S_ENT;
                end else begin
                    if (cp_rd == '0 && ds_rd < lw_rd) begin
                        lw_we = 1'b1; lw_wd = ds_rd;
                    end
                    state_next = S_TOP;
                end
            end
            S_FIN: begin
                lowv_next = lw_rd;
                if (lw_rd == ds_rd) begin
                    comps_next = comps_reg + 1'b1;
                    state_next = S_POP;
                end else begin
                    state_next = S_RET;
                end
            end
            S_POP: begin
                sc_ra = vix(sp0_reg);
                if (sp0_reg == '0) begin
                    state_next = S_RET;
                end else begin
                    sp0_next = sp0_reg - 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW: begin
                cp_we = 1'b1; cp_wa = vix(sc_rd); cp_wd = comps_reg;
                state_next = (sc_rd == v_reg) ? S_RET : S_POP;
            end
            S_RET: begin
                sp1_next = sp1_reg - 1'b1;
                cv_ra = vix(sp1_reg - 1'b1);
                state_next = (sp1_reg > VW'(1)) ? S_RETW : S_TOP;
            end
            S_RETW: begin
                u_next = cv_rd;
                lw_ra = vix(cv_rd);
                state_next = S_RETW2;
            end
            S_RETW2: begin
                if (lowv_reg < lw_rd) begin
                    lw_we = 1'b1; lw_wa = vix(u_reg); lw_wd = lowv_reg;
                end
                state_next = S_TOP;
            end
            S_MK: begin
                hd_ra = vix(r_reg); cp_ra = vix(r_reg);
                if (r_reg > n) begin
                    k_next = '0; i_next = '0; mask_next = '0;
                    state_next = S_OB;
                end else begin
                    state_next = S_MKW;
                end
            end
            S_MKW: begin
                e_next = hd_rd; cv_next = cp_rd;
                state_next = S_MKL;
            end
            S_MKL: begin
                if (e_reg == '0) begin
                    r_next = r_reg + 1'b1;
                    state_next = S_MK;
                end else begin
                    state_next = S_MKE;
                end
            end
            S_MKE: begin
                nxt_next = nx_rd;
                cp_ra = vix(w);
                if (w != '0 && w <= n) begin
                    state_next = S_MKC;
                end else begin
                    e_next = nx_rd;
                    state_next = S_MKL;
                end
            end
            S_MKC: begin
                if (cp_rd != cv_reg && cv_reg != '0) begin
                    ex_we = 1'b1; ex_wa = vix(cv_reg); ex_wd = 1'b1;
                end
                e_next = nxt_reg;
                state_next = S_MKL;
            end
            S_OB: begin
                cp_ra = i_reg[VA-1:0];
                if (VW'(i_reg) >= n) begin
                    ov_next = 1'b1;
                    ow_next = '{mask_reg, 6'(k_reg), (k_reg + 1'b1) == words, ovf_reg};
                    state_next = S_WAIT;
                end else begin
                    state_next = S_OBW;
                end
            end
            S_OBW: begin
                cz_next = (cp_rd == '0);
                ex_ra = vix(cp_rd);
                state_next = S_OBX;
            end
            S_OBX: begin
                mask_next[i_reg[5:0]] = !cz_reg && !ex_rd;
                i_next = i_reg + 1'b1;
                if (bit_last) begin
                    ov_next = 1'b1;
                    ow_next = '{mask_next, 6'(k_reg), (k_reg + 1'b1) == words, ovf_reg};
                    state_next = S_WAIT;
                end else begin
                    state_next = S_OB;
                end
            end
            S_WAIT: begin
                if (out_ready) begin
                    ov_next = 1'b0;
                    if (ow_reg.last_word) begin
                        i_next = '0; total_next = '0; ovf_next = 1'b0;
                        state_next = S_CLRH;
                    end else begin
                        k_next = k_reg + 1'b1;
                        i_next = IW'({k_reg + 1'b1, 6'b000000});
                        mask_next = '0;
                        state_next = S_OB;
                    end
                end
            end
            default: begin
                state_next = S_CLRH;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLRH;
            i_reg     <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
        r_reg <= r_next; seq_reg <= seq_next; sp0_reg <= sp0_next; sp1_reg <= sp1_next;
        comps_reg <= comps_next; x_reg <= x_next; v_reg <= v_next; u_reg <= u_next;
        lowv_reg <= lowv_next; cv_reg <= cv_next; e_reg <= e_next; nxt_reg <= nxt_next;
        cz_reg <= cz_next; k_reg <= k_next; mask_reg <= mask_next; item_reg <= item_next;
        ow_reg <= ow_next;
    end
endmodule

// ----- rtl/graph_sink_components.sv -----
// Top level: stream ports, vertex count register and the sink component engine.
//
// Edges that are stored load with a head-of-list read as the beat is taken, then a store;
// ignored or dropped beats skip the store. s_tready is high only while waiting for a beat.
// A beat with tlast starts the computation: a clearing pass of the per-vertex stores,
// an iterative Tarjan walk over the stored edges on single-write, single-read memories,
// an exit-marking pass over every edge list, then a pass over the vertices that builds
// the output words, one beat per 64 vertices. After the final word a further pass clears
// the list heads, a pass also run after reset; s_tready stays low throughout.
// Configuration writes are taken at any time.
module graph_sink_components
    import gsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,    // vertex_count [10:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // edge_source [10:0], edge_target [21:11]
    input  logic        s_tuser,     // edge_valid
    input  logic        s_tlast,     // last_edge
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,     // sink_mask [63:0], word_index [69:64]
    output logic        m_tuser,     // edge_overflow
    output logic        m_tlast      // last_word
);
    logic [VW-1:0] vcount_reg;
    logic [VW-1:0] n;
    edge_item_t    item;
    sink_word_t    word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VW'(MAX_VERTICES);
        end else if (cfg_valid) begin
            vcount_reg <= cfg_data[VW-1:0];
        end
    end

    assign n = (vcount_reg > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vcount_reg;
    assign item = '{s_tdata[10:0], s_tdata[21:11], s_tuser, s_tlast};

    gsc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .n         (n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (word)
    );

    assign m_tdata = {2'b00, word.word_index, word.sink_mask};
    assign m_tlast = word.last_word;
    assign m_tuser = word.edge_overflow;
endmodule

// ----- rtl/gsc_checker.sv -----
// Port checker for the sink component finder, bound to the top level.
module gsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result waits");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !s_tready && !m_tvalid)
        else $error("no clearing pass after final word");

    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !s_tready)
        else $error("input ready inside a word run");
endmodule

bind graph_sink_components gsc_checker u_gsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
